// ===== hw/rtl/tfm_pkg.sv =====
// ----------------------------------------------------------------------------
// TFM delay-and-sum package
// Shared types, geometry constants and the elaboration-time one-way delay
// function used by the delay-and-sum accumulator.
// ----------------------------------------------------------------------------
package tfm_pkg;

   // Array and grid size
   localparam int NUM_ELEMENTS      = 32;
   localparam int GRID_ROWS         = 2;
   localparam int GRID_COLS         = 3;
   localparam int SAMPLES_PER_ASCAN = 1024;
   localparam int NUM_PIXELS        = GRID_ROWS * GRID_COLS;

   // Field widths
   localparam int ELEM_W  = 5;
   localparam int INDEX_W = 10;
   localparam int AMP_W   = 16;
   localparam int ROW_W   = 1;
   localparam int COL_W   = 2;
   localparam int SUM_W   = 26;
   localparam int DELAY_W = 16;
   localparam int CNT_W   = $clog2(NUM_PIXELS + 1);

   // Input transaction
   typedef struct packed {
      logic [ELEM_W-1:0]  tx_element;
      logic [ELEM_W-1:0]  rx_element;
      logic [INDEX_W-1:0] sample_index;
      logic [AMP_W-1:0]   sample_amplitude;
      logic               end_of_frame;
   } req_payload_type;

   // Result transaction
   typedef struct packed {
      logic [ROW_W-1:0] pixel_row;
      logic [COL_W-1:0] pixel_col;
      logic [SUM_W-1:0] pixel_sum;
      logic             last_pixel;
   } rsp_payload_type;

   // Pixel sums gathered by an end-of-frame transaction on its way down the chain
   typedef logic [NUM_PIXELS-1:0][SUM_W-1:0] sum_vec_type;

   // Delays from every element to one pixel
   typedef logic [NUM_ELEMENTS-1:0][DELAY_W-1:0] delay_col_type;

   // Transaction as it travels from cell to cell
   typedef struct packed {
      logic [ELEM_W-1:0]  tx_element;
      logic [ELEM_W-1:0]  rx_element;
      logic [INDEX_W-1:0] sample_index;
      logic [AMP_W-1:0]   sample_amplitude;
      logic               end_of_frame;
      logic               in_range;
      sum_vec_type        sums;
   } stage_type;

   // Exact integer square root, bit by bit. Only ever evaluated on constants.
   function automatic longint unsigned isqrt(input longint unsigned value);
      longint unsigned v;
      longint unsigned res;
      longint unsigned bitval;
      v      = value;
      res    = 0;
      bitval = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bitval) begin
            v   = v - (res + bitval);
            res = (res >> 1) + bitval;
         end else begin
            res = res >> 1;
         end
         bitval = bitval >> 2;
      end
      return res;
   endfunction

   // One-way delay in Q8.8 samples from element e to pixel (r, c).
   // Coordinates are in 0.05 mm units; the delay is 2560*sqrt(S)/51 rounded.
   function automatic logic [DELAY_W-1:0] compute_delay(input int e, input int r, input int c);
      longint          ex;
      longint          px;
      longint          py;
      longint          dx;
      longint unsigned s;
      longint unsigned root;
      longint unsigned q;
      ex   = 5 + 22 * longint'(e);
      px   = 80 + 160 * longint'(c);
      py   = 80 + 160 * longint'(r);
      dx   = px - ex;
      s    = longint'(dx * dx) + longint'(py * py);
      root = isqrt(s * 64'd6553600);
      q    = (root + 64'd25) / 64'd51;
      if (q > 64'd65535) begin
         q = 64'd65535;
      end
      return q[DELAY_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/tfm_cell.sv =====
// ----------------------------------------------------------------------------
// TFM pixel cell
// One pixel of the image: looks up the tx and rx delays of each passing
// sample, accumulates matching amplitudes and hands the transaction on.
// ----------------------------------------------------------------------------
module tfm_cell
   import tfm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  delay_col_type delay_col,
   input  logic          in_valid,
   input  stage_type     in_item,
   output logic          out_valid,
   output stage_type     out_item
);

   logic              out_valid_ff;
   logic              out_valid_in;
   stage_type         out_item_ff;
   stage_type         out_item_in;
   logic [SUM_W-1:0]  acc_ff;
   logic [SUM_W-1:0]  acc_in;
   logic [DELAY_W:0]  delay_sum;
   logic [INDEX_W:0]  target_plus_one;
   logic [INDEX_W:0]  index_plus_one;
   logic              hit;
   logic [SUM_W:0]    acc_add;

   // Round-trip delay of this pixel for the transaction's element pair
   always_comb begin
      delay_sum       = {1'b0, delay_col[in_item.tx_element]}
                      + {1'b0, delay_col[in_item.rx_element]};
      target_plus_one = (INDEX_W + 1)'(delay_sum[DELAY_W:8]);
      index_plus_one  = {1'b0, in_item.sample_index} + (INDEX_W + 1)'(1);
      hit             = in_item.in_range && (target_plus_one == index_plus_one);
      acc_add         = {1'b0, acc_ff} + (SUM_W + 1)'(in_item.sample_amplitude);
   end

   // Accumulator update: saturating add on a hit, clear at end of frame
   always_comb begin
      acc_in = acc_ff;
      if (advance && in_valid) begin
         if (in_item.end_of_frame) begin
            acc_in = '0;
         end else if (hit) begin
            acc_in = acc_add[SUM_W] ? {SUM_W{1'b1}} : acc_add[SUM_W-1:0];
         end
      end
   end

   // Forward the transaction; this cell's sum enters the top of the sum lane
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in  = in_valid;
         out_item_in   = in_item;
         out_item_in.sums = {acc_ff, in_item.sums[NUM_PIXELS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

// ===== hw/rtl/tfm_serializer.sv =====
// ----------------------------------------------------------------------------
// TFM result serialiser
// Holds the pixel sums of one frame and issues them one transaction per
// pixel in row-major order.
// ----------------------------------------------------------------------------
module tfm_serializer
   import tfm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  sum_vec_type     load_sums,
   output logic            can_load,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   sum_vec_type      sums_ff;
   sum_vec_type      sums_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic             pop;

   assign pop      = (cnt_ff != '0) && rsp_ready;
   assign can_load = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && rsp_ready);

   // Load a new frame, or step to the next pixel on each accepted transaction
   always_comb begin
      cnt_in  = cnt_ff;
      sums_in = sums_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (load) begin
         cnt_in  = CNT_W'(NUM_PIXELS);
         sums_in = load_sums;
         row_in  = '0;
         col_in  = '0;
      end else if (pop) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         sums_in = sums_ff >> SUM_W;
         if (col_ff == COL_W'(GRID_COLS - 1)) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      sums_ff <= sums_in;
   end

   // Result driven straight from registers
   assign rsp_valid              = (cnt_ff != '0);
   assign rsp_payload.pixel_row  = row_ff;
   assign rsp_payload.pixel_col  = col_ff;
   assign rsp_payload.pixel_sum  = sums_ff[0];
   assign rsp_payload.last_pixel = (cnt_ff == CNT_W'(1));

endmodule

// ===== hw/rtl/tfm_delay_and_sum_accumulator.sv =====
// ----------------------------------------------------------------------------
// TFM delay-and-sum accumulator
// Total focusing method imaging over full-matrix-capture samples.
// ----------------------------------------------------------------------------
// Usage:
// Each req transaction carries one A-scan sample (tx element, rx element,
// sample index, Q0.16 amplitude) or an end-of-frame marker. Samples pass
// down a row of six pixel cells, one cell per cycle while the row advances;
// each cell adds the amplitude to its pixel sum when the round-trip delay lands on the sample.
// An end-of-frame transaction collects every pixel sum on its way down and
// clears them; six rsp transactions then follow in row-major order, the
// last one flagged by last_pixel.
// Throughput is one sample per cycle while the row is not stalled. The first
// result of a frame follows once the end-of-frame has left the last cell and
// loaded the result buffer; the rest follow back to back while rsp_ready is high.
// If a frame's results are still being drained when the next end-of-frame
// reaches the end of the cell row, the whole row stalls and req_ready falls;
// a stalled receiver therefore stalls the input only through that path.
// Reset clears all pixel sums and empties the cell row and result buffer.
// ----------------------------------------------------------------------------
module tfm_delay_and_sum_accumulator
   import tfm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   delay_col_type delay_tab   [NUM_PIXELS];
   logic          stage_valid [NUM_PIXELS+1];
   stage_type     stage_item  [NUM_PIXELS+1];
   stage_type     head_item;
   logic          advance;
   logic          tail_eof;
   logic          ser_load;
   logic          ser_can_load;

   // Build-time delay table, one column of element delays per pixel
   for (genvar p = 0; p < NUM_PIXELS; p++) begin : g_pix_tab
      for (genvar e = 0; e < NUM_ELEMENTS; e++) begin : g_elem_tab
         assign delay_tab[p][e] = compute_delay(e, p / GRID_COLS, p % GRID_COLS);
      end
   end

   // Head of the chain: incoming transaction with its range check
   always_comb begin
      head_item.tx_element       = req_payload.tx_element;
      head_item.rx_element       = req_payload.rx_element;
      head_item.sample_index     = req_payload.sample_index;
      head_item.sample_amplitude = req_payload.sample_amplitude;
      head_item.end_of_frame     = req_payload.end_of_frame;
      head_item.in_range         = (int'(req_payload.tx_element) < NUM_ELEMENTS)
                                && (int'(req_payload.rx_element) < NUM_ELEMENTS)
                                && (int'(req_payload.sample_index) < SAMPLES_PER_ASCAN);
      head_item.sums             = '0;
   end

   assign stage_valid[0] = req_valid;
   assign stage_item[0]  = head_item;

   // Row of pixel cells
   for (genvar p = 0; p < NUM_PIXELS; p++) begin : g_cell
      tfm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .delay_col (delay_tab[p]),
         .in_valid  (stage_valid[p]),
         .in_item   (stage_item[p]),
         .out_valid (stage_valid[p+1]),
         .out_item  (stage_item[p+1])
      );
   end

   // The chain moves unless a finished frame waits for the result buffer
   assign tail_eof  = stage_valid[NUM_PIXELS] && stage_item[NUM_PIXELS].end_of_frame;
   assign ser_load  = tail_eof && ser_can_load;
   assign advance   = !tail_eof || ser_can_load;
   assign req_ready = advance;

   // Result buffer
   tfm_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .load        (ser_load),
      .load_sums   (stage_item[NUM_PIXELS].sums),
      .can_load    (ser_can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // The input stalls only behind an end-of-frame waiting at the chain's end
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> tail_eof)
      else $error("input stalled without a pending end of frame");

   // The final pixel of a frame is the bottom-right one
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_pixel |->
         (rsp_payload.pixel_row == ROW_W'(GRID_ROWS - 1))
         && (rsp_payload.pixel_col == COL_W'(GRID_COLS - 1)))
      else $error("last pixel flagged away from the final grid position");

   // After the last pixel, either the buffer empties or a new frame starts at the origin
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.last_pixel |=>
         !rsp_valid || ((rsp_payload.pixel_row == '0) && (rsp_payload.pixel_col == '0)))
      else $error("result buffer did not restart at the first pixel");

endmodule
